/* hdl/fwr_pkg.sv */
`default_nettype none

package fwr_pkg;

    typedef enum logic [1:0] {
        OP_SELECT  = 2'd0,
        OP_REQUEUE = 2'd1,
        OP_APPEND  = 2'd2,
        OP_REMOVE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    localparam int unsigned TASK_ID_W = 16;
    localparam int unsigned COUNT_W   = 7;

    typedef struct packed {
        op_t                  func;
        logic [TASK_ID_W-1:0] task_id;
    } cmd_word_t;

    typedef struct packed {
        logic [TASK_ID_W-1:0] front_id;
        logic                 is_empty;
        status_t              status;
        logic [COUNT_W-1:0]   entry_count;
    } rsp_word_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_FRONT,
        S_LOAD
    } seq_state_t;

endpackage

`default_nettype wire

/* hdl/fwr_ram.sv */
`default_nettype none

module fwr_ram #(
    parameter int unsigned DEPTH = 64,
    parameter int unsigned WIDTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read-first: a read of the address being written returns the old entry
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hdl/fifo_worklist_with_requeue_core.sv */
// Select and append go from acceptance through the front read to the word loading.
// Requeue and remove scan one entry per cycle, then close the gap one entry per cycle.
// One operation at a time: cmd_stall is high after acceptance until the word is loaded,
// which waits while the previous word is stalled.
// Reset (rst_n low, asynchronous) empties the list at once; RAM contents are not cleared.
`default_nettype none

module fifo_worklist_with_requeue_core #(
    parameter int unsigned DEPTH   = 64,
    parameter int unsigned ID_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cmd_valid,
    output logic                   cmd_stall,
    input  wire fwr_pkg::cmd_word_t cmd,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    output fwr_pkg::rsp_word_t     rsp
);

    localparam int unsigned AW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    fwr_pkg::seq_state_t state_reg, state_next;
    fwr_pkg::op_t        op_reg, op_next;
    fwr_pkg::status_t    status_reg, status_next;
    logic [ID_BITS-1:0]  key_reg, key_next;
    logic [CW-1:0]       len_reg, len_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       pos_reg, pos_next;
    logic                vld_reg, vld_next;
    logic                rsp_valid_reg, rsp_valid_next;
    fwr_pkg::rsp_word_t  rsp_reg, rsp_next;

    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [ID_BITS-1:0] mem_wdata;
    logic [AW-1:0]      mem_raddr;
    logic [ID_BITS-1:0] mem_rdata;

    logic          cmd_take;
    logic          found;
    logic          exhausted;
    logic          issue;
    logic          load;
    logic [CW-1:0] pos_less;
    logic [CW-1:0] len_less;
    logic [31:0]   front_wide;

    fwr_ram #(
        .DEPTH (DEPTH),
        .WIDTH (ID_BITS)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign cmd_stall = (state_reg != fwr_pkg::S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign found     = vld_reg && (mem_rdata == key_reg);
    assign exhausted = !vld_reg && (ptr_reg >= len_reg);
    assign issue     = (ptr_reg < len_reg);
    assign load      = (state_reg == fwr_pkg::S_LOAD) && (!rsp_valid_reg || !rsp_stall);
    assign pos_less  = pos_reg - ONE_C;
    assign len_less  = len_reg - ONE_C;
    assign front_wide = 32'(mem_rdata);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fwr_pkg::S_IDLE:
            begin
                if (cmd_take)
                begin
                    if (cmd.func == fwr_pkg::OP_REQUEUE || cmd.func == fwr_pkg::OP_REMOVE)
                    begin
                        state_next = fwr_pkg::S_SEARCH;
                    end
                    else
                    begin
                        state_next = fwr_pkg::S_FRONT;
                    end
                end
            end
            fwr_pkg::S_SEARCH:
            begin
                if (found)
                begin
                    state_next = fwr_pkg::S_SHIFT;
                end
                else if (exhausted)
                begin
                    state_next = fwr_pkg::S_FRONT;
                end
            end
            fwr_pkg::S_SHIFT:
            begin
                if (exhausted)
                begin
                    state_next = fwr_pkg::S_FRONT;
                end
            end
            fwr_pkg::S_FRONT:
            begin
                state_next = fwr_pkg::S_LOAD;
            end
            fwr_pkg::S_LOAD:
            begin
                if (load)
                begin
                    state_next = fwr_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fwr_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        op_next     = op_reg;
        status_next = status_reg;
        key_next    = key_reg;
        len_next    = len_reg;
        ptr_next    = ptr_reg;
        pos_next    = pos_reg;
        vld_next    = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = len_reg[AW-1:0];
        mem_wdata   = key_reg;
        mem_raddr   = ptr_reg[AW-1:0];

        unique case (state_reg)
            fwr_pkg::S_IDLE:
            begin
                if (cmd_take)
                begin
                    op_next     = cmd.func;
                    key_next    = ID_BITS'(cmd.task_id);
                    status_next = fwr_pkg::ST_OK;
                    ptr_next    = '0;
                    if (cmd.func == fwr_pkg::OP_APPEND)
                    begin
                        if (len_reg < DEPTH_C)
                        begin
                            mem_we    = 1'b1;
                            mem_wdata = ID_BITS'(cmd.task_id);
                            len_next  = len_reg + ONE_C;
                        end
                        else
                        begin
                            status_next = fwr_pkg::ST_FULL;
                        end
                    end
                end
            end
            fwr_pkg::S_SEARCH:
            begin
                if (found)
                begin
                    ptr_next = pos_reg + ONE_C;
                end
                else if (exhausted)
                begin
                    status_next = fwr_pkg::ST_NOT_FOUND;
                end
                else if (issue)
                begin
                    ptr_next = ptr_reg + ONE_C;
                    pos_next = ptr_reg;
                    vld_next = 1'b1;
                end
            end
            fwr_pkg::S_SHIFT:
            begin
                if (vld_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = pos_less[AW-1:0];
                    mem_wdata = mem_rdata;
                end
                if (exhausted)
                begin
                    // requeue: the freed tail slot takes the key, count unchanged
                    if (op_reg == fwr_pkg::OP_REQUEUE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = len_less[AW-1:0];
                    end
                    else
                    begin
                        len_next = len_less;
                    end
                end
                else if (issue)
                begin
                    ptr_next = ptr_reg + ONE_C;
                    pos_next = ptr_reg;
                    vld_next = 1'b1;
                end
            end
            fwr_pkg::S_FRONT,
            fwr_pkg::S_LOAD:
            begin
                mem_raddr = '0;
            end
            default:
            begin
                mem_raddr = '0;
            end
        endcase
    end

    always_comb
    begin
        rsp_next             = rsp_reg;
        rsp_next.is_empty    = (len_reg == '0);
        rsp_next.front_id    = (len_reg == '0) ? '0 : front_wide[fwr_pkg::TASK_ID_W-1:0];
        rsp_next.status      = status_reg;
        rsp_next.entry_count = fwr_pkg::COUNT_W'(len_reg);

        rsp_valid_next = rsp_valid_reg && rsp_stall;
        if (load)
        begin
            rsp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fwr_pkg::S_IDLE;
            len_reg       <= '0;
            vld_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            vld_reg       <= vld_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        key_reg    <= key_next;
        ptr_reg    <= ptr_next;
        pos_reg    <= pos_next;
        if (load)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= DEPTH_C)
        else $error("entry count beyond depth");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |=> cmd_stall)
        else $error("command port free right after a take");

    a_shift_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == fwr_pkg::S_SHIFT) && vld_reg |-> pos_less < ptr_reg)
        else $error("gap close writes at or beyond the read pointer");

    a_full_only_at_depth: assert property (@(posedge clk) disable iff (!rst_n)
        load && (status_reg == fwr_pkg::ST_FULL) |-> len_reg == DEPTH_C)
        else $error("full reported below depth");

endmodule

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int unsigned LIST_DEPTH = 64;
    localparam int unsigned N_RANDOM   = 2000;
    localparam int unsigned DRAIN_WAIT = 2 * LIST_DEPTH + 16;
    localparam int unsigned ID_W       = fwr_pkg::TASK_ID_W;
    localparam int unsigned CNT_W      = fwr_pkg::COUNT_W;

    typedef struct packed {
        fwr_pkg::op_t     func;
        logic [ID_W-1:0]  task_id;
        bit               typed;
        logic [ID_W-1:0]  front_id;
        logic             is_empty;
        fwr_pkg::status_t status;
        logic [CNT_W-1:0] entry_count;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cmd_valid;
    logic               cmd_stall;
    fwr_pkg::cmd_word_t cmd;
    logic               rsp_valid;
    logic               rsp_stall;
    fwr_pkg::rsp_word_t rsp;

    logic [ID_W-1:0]    worklist_model[$];
    fwr_pkg::rsp_word_t pending_rsp[$];
    int                 mismatches = 0;
    bit                 cmd_burst = 1'b0;
    bit                 rsp_burst = 1'b0;

    dir_row_t directed [0:20] = '{
        '{fwr_pkg::OP_SELECT,  16'hFFFF, 1'b1, 16'h0000, 1'b1, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_REMOVE,  16'h0000, 1'b1, 16'h0000, 1'b1, fwr_pkg::ST_NOT_FOUND, 7'd0},
        '{fwr_pkg::OP_REQUEUE, 16'hFFFF, 1'b1, 16'h0000, 1'b1, fwr_pkg::ST_NOT_FOUND, 7'd0},
        '{fwr_pkg::OP_APPEND,  16'hFFFF, 1'b1, 16'hFFFF, 1'b0, fwr_pkg::ST_OK,        7'd1},
        '{fwr_pkg::OP_APPEND,  16'h0000, 1'b1, 16'hFFFF, 1'b0, fwr_pkg::ST_OK,        7'd2},
        '{fwr_pkg::OP_APPEND,  16'hFFFF, 1'b1, 16'hFFFF, 1'b0, fwr_pkg::ST_OK,        7'd3},
        '{fwr_pkg::OP_SELECT,  16'h1234, 1'b1, 16'hFFFF, 1'b0, fwr_pkg::ST_OK,        7'd3},
        '{fwr_pkg::OP_REQUEUE, 16'hFFFF, 1'b1, 16'h0000, 1'b0, fwr_pkg::ST_OK,        7'd3},
        '{fwr_pkg::OP_REMOVE,  16'hFFFF, 1'b0, 16'h0000, 1'b0, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_REMOVE,  16'hABCD, 1'b1, 16'h0000, 1'b0, fwr_pkg::ST_NOT_FOUND, 7'd2},
        '{fwr_pkg::OP_REQUEUE, 16'h0000, 1'b0, 16'h0000, 1'b0, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_APPEND,  16'h5555, 1'b0, 16'h0000, 1'b0, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_APPEND,  16'hAAAA, 1'b0, 16'h0000, 1'b0, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_REQUEUE, 16'h5555, 1'b0, 16'h0000, 1'b0, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_REMOVE,  16'hAAAA, 1'b0, 16'h0000, 1'b0, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_REMOVE,  16'hFFFF, 1'b0, 16'h0000, 1'b0, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_REMOVE,  16'h0000, 1'b0, 16'h0000, 1'b0, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_REMOVE,  16'h5555, 1'b1, 16'h0000, 1'b1, fwr_pkg::ST_OK,        7'd0},
        '{fwr_pkg::OP_APPEND,  16'h8001, 1'b1, 16'h8001, 1'b0, fwr_pkg::ST_OK,        7'd1},
        '{fwr_pkg::OP_REQUEUE, 16'h8001, 1'b1, 16'h8001, 1'b0, fwr_pkg::ST_OK,        7'd1},
        '{fwr_pkg::OP_REMOVE,  16'h8001, 1'b1, 16'h0000, 1'b1, fwr_pkg::ST_OK,        7'd0}
    };

    fifo_worklist_with_requeue_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic int draw_gap(input bit burst);
        if (burst)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    function automatic fwr_pkg::rsp_word_t apply_op(input fwr_pkg::cmd_word_t w);
        fwr_pkg::rsp_word_t r;
        int                 pos;
        r.status = fwr_pkg::ST_OK;
        pos = -1;
        if (w.func == fwr_pkg::OP_APPEND)
        begin
            if (worklist_model.size() >= LIST_DEPTH)
                r.status = fwr_pkg::ST_FULL;
            else
                worklist_model.insert(worklist_model.size(), w.task_id);
        end
        else if (w.func == fwr_pkg::OP_REQUEUE || w.func == fwr_pkg::OP_REMOVE)
        begin
            foreach (worklist_model[i])
                if (pos < 0 && worklist_model[i] == w.task_id)
                    pos = i;
            if (pos < 0)
                r.status = fwr_pkg::ST_NOT_FOUND;
            else
            begin
                worklist_model.delete(pos);
                if (w.func == fwr_pkg::OP_REQUEUE)
                    worklist_model.insert(worklist_model.size(), w.task_id);
            end
        end
        r.is_empty    = (worklist_model.size() == 0);
        r.front_id    = r.is_empty ? '0 : worklist_model[0];
        r.entry_count = CNT_W'(worklist_model.size());
        return r;
    endfunction

    function automatic logic [ID_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55 && worklist_model.size() > 0)
            return worklist_model[$urandom_range(0, worklist_model.size() - 1)];
        if (r < 75)
            return ID_W'($urandom);
        if (r < 85)
            return $urandom_range(0, 1) ? '1 : '0;
        return ID_W'($urandom_range(0, 7));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic issue(input fwr_pkg::cmd_word_t w, input bit typed,
                         input fwr_pkg::rsp_word_t typed_rsp);
        int                 gap;
        fwr_pkg::rsp_word_t predicted;
        if ($urandom_range(0, 63) == 0)
            cmd_burst = !cmd_burst;
        gap = draw_gap(cmd_burst);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= w;
        do
            @(posedge clk);
        while (!(cmd_valid && !cmd_stall));
        predicted = apply_op(w);
        pending_rsp.insert(pending_rsp.size(), typed ? typed_rsp : predicted);
        @(negedge clk);
    endtask

    initial
    begin
        fwr_pkg::rsp_word_t exp_w;
        rsp_stall = 1'b1;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            int gap;
            if ($urandom_range(0, 63) == 0)
                rsp_burst = !rsp_burst;
            gap = draw_gap(rsp_burst);
            if (gap > 0)
            begin
                rsp_stall <= 1'b1;
                repeat (gap) @(negedge clk);
            end
            rsp_stall <= 1'b0;
            do
                @(posedge clk);
            while (!(rsp_valid && !rsp_stall));
            if (pending_rsp.size() == 0)
            begin
                $error("unexpected word: front_id %0h entry_count %0d",
                       rsp.front_id, rsp.entry_count);
                mismatches++;
            end
            else
            begin
                exp_w = pending_rsp[0];
                pending_rsp.delete(0);
                if (rsp.front_id !== exp_w.front_id)
                begin
                    $error("front_id: expected %0h, got %0h", exp_w.front_id, rsp.front_id);
                    mismatches++;
                end
                if (rsp.is_empty !== exp_w.is_empty)
                begin
                    $error("is_empty: expected %0d, got %0d", exp_w.is_empty, rsp.is_empty);
                    mismatches++;
                end
                if (rsp.status !== exp_w.status)
                begin
                    $error("status: expected %0d, got %0d", exp_w.status, rsp.status);
                    mismatches++;
                end
                if (rsp.entry_count !== exp_w.entry_count)
                begin
                    $error("entry_count: expected %0d, got %0d",
                           exp_w.entry_count, rsp.entry_count);
                    mismatches++;
                end
            end
            @(negedge clk);
        end
    end

    initial
    begin
        fwr_pkg::cmd_word_t w;
        fwr_pkg::rsp_word_t typed_rsp;
        bit                 filling;
        int                 full_extra;
        int                 r;
        rst_n     = 1'b0;
        cmd_valid = 1'b0;
        cmd       = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed[i])
        begin
            w.func                = directed[i].func;
            w.task_id             = directed[i].task_id;
            typed_rsp.front_id    = directed[i].front_id;
            typed_rsp.is_empty    = directed[i].is_empty;
            typed_rsp.status      = directed[i].status;
            typed_rsp.entry_count = directed[i].entry_count;
            issue(w, directed[i].typed, typed_rsp);
        end

        // alternate fill and drain so the list swings between empty and full
        filling    = 1'b1;
        full_extra = 0;
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (filling && worklist_model.size() >= LIST_DEPTH)
            begin
                full_extra++;
                if (full_extra > $urandom_range(1, 6))
                begin
                    filling    = 1'b0;
                    full_extra = 0;
                end
            end
            else if (!filling && worklist_model.size() == 0)
                filling = 1'b1;
            else if ($urandom_range(0, 99) < 2)
                filling = !filling;
            r = $urandom_range(0, 99);
            if (filling)
                w.func = fwr_pkg::op_t'((r < 60) ? fwr_pkg::OP_APPEND :
                                        (r < 75) ? fwr_pkg::OP_REQUEUE :
                                        (r < 85) ? fwr_pkg::OP_REMOVE : fwr_pkg::OP_SELECT);
            else
                w.func = fwr_pkg::op_t'((r < 50) ? fwr_pkg::OP_REMOVE :
                                        (r < 70) ? fwr_pkg::OP_REQUEUE :
                                        (r < 85) ? fwr_pkg::OP_APPEND : fwr_pkg::OP_SELECT);
            w.task_id = pick_key();
            issue(w, 1'b0, '0);
        end
        cmd_valid <= 1'b0;

        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0)
            $display("PASS fifo_worklist_with_requeue_core");
        else
            $display("FAIL fifo_worklist_with_requeue_core");
        $finish;
    end

    initial
    begin
        #15_000_000;
        $display("FAIL fifo_worklist_with_requeue_core");
        $finish;
    end

endmodule

/* files.f */
hdl/fwr_pkg.sv
hdl/fwr_ram.sv
hdl/fifo_worklist_with_requeue_core.sv
tb/tb.sv
